// ----- rtl/sli_pkg.sv -----
// shared constants, status codes and control types for the sorted list block
`default_nettype none
package sli_pkg;

   localparam int CAPACITY    = 64;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef struct packed {
      logic load;
      logic update;
   } sli_cmd_type;

endpackage
`default_nettype wire

// ----- rtl/sorted_list_insert_remove.sv -----
// top level of the sorted list block: ordered signed store with insert and remove
//
// the request channel carries an operation (insert or remove) and a signed
// 32-bit value; each request beat yields exactly one response beat with a
// status, the entry count after the request and an empty flag
// entries are held in ascending signed order; an insert lands ahead of equal
// entries, a remove deletes the first equal entry
// a request runs as a compare step and then an update step: in the accept
// cycle every cell compares its entry with the value and the result vectors
// are registered; in the update state the cells from the insert or remove
// position on take the new value or a neighbor in parallel and the response
// register loads; response valid is registered and rises as the update state
// ends, and a new request is not taken until the update of the last is done
// req_stall is high while a request is being applied
// if rsp_stall holds a response, the next request is still accepted and
// compared, and its update waits until the response register frees up
// reset clears the entry count and all handshake state; no clearing pass runs
`default_nettype none
module sorted_list_insert_remove (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_operation,
   input  wire signed [sli_pkg::VALUE_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [sli_pkg::STATUS_W-1:0]         rsp_status,
   output logic [sli_pkg::COUNT_OUT_W-1:0]      rsp_entry_count,
   output logic                                 rsp_is_empty
);
   import sli_pkg::*;

   sli_cmd_type cmd;

   sli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sli_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule
`default_nettype wire

// ----- rtl/sli_ctrl.sv -----
// request sequencing and response valid control for the sorted list block
`default_nettype none
module sli_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output sli_pkg::sli_cmd_type cmd
);
   import sli_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.update = (state_ff == ST_UPDATE) && rsp_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sli_datapath.sv -----
// sorted entry cells, per-cell compare vectors, count and response registers
`default_nettype none
module sli_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  sli_pkg::sli_cmd_type                 cmd,
   input  wire                                  req_operation,
   input  wire signed [sli_pkg::VALUE_W-1:0]    req_value,
   output logic [sli_pkg::STATUS_W-1:0]         rsp_status,
   output logic [sli_pkg::COUNT_OUT_W-1:0]      rsp_entry_count,
   output logic                                 rsp_is_empty
);
   import sli_pkg::*;

   logic signed [VALUE_W-1:0] store_ff [CAPACITY];
   logic [CAPACITY-1:0]       lt_ff, eq_ff;
   logic [CAPACITY-1:0]       cell_valid, hit;
   logic                      op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      found, full, empty, ok;
   status_type                status_in;
   logic [STATUS_W-1:0]       status_ff;
   logic [COUNT_OUT_W-1:0]    entry_count_ff;
   logic                      is_empty_ff;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_valid[i] = (CNT_W'(i) < count_ff);
      end
   end

   // first equal entry sits right after the last smaller one
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            hit[i] = eq_ff[i];
         end else begin
            hit[i] = eq_ff[i] && lt_ff[i-1];
         end
      end
   end

   assign found = |hit;
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      ok        = 1'b0;
      if (op_ff == OP_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            ok       = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = STATUS_EMPTY;
         end else if (!found) begin
            status_in = STATUS_NOT_FOUND;
         end else begin
            ok       = 1'b1;
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
         for (int i = 0; i < CAPACITY; i++) begin
            lt_ff[i] <= cell_valid[i] && (store_ff[i] < req_value);
            eq_ff[i] <= cell_valid[i] && (store_ff[i] == req_value);
         end
      end
   end

   // each cell keeps, takes the new value, or takes a neighbor
   always_ff @(posedge clock) begin
      if (cmd.update && ok) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (!lt_ff[i]) begin
               if (op_ff == OP_INSERT) begin
                  if (i == 0) begin
                     store_ff[i] <= value_ff;
                  end else if (lt_ff[i-1]) begin
                     store_ff[i] <= value_ff;
                  end else begin
                     store_ff[i] <= store_ff[i-1];
                  end
               end else if (i < CAPACITY - 1) begin
                  store_ff[i] <= store_ff[i+1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.update) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         status_ff      <= status_in;
         entry_count_ff <= COUNT_OUT_W'(count_in);
         is_empty_ff    <= (count_in == '0);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_is_empty    = is_empty_ff;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking bench for sorted_list_insert_remove with directed and random insert and remove traffic
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import sli_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      op_type                   op;
      logic signed [VALUE_W-1:0] value;
   } list_request_type;

   typedef struct packed {
      status_type              status;
      logic [COUNT_OUT_W-1:0]  entry_count;
      logic                    is_empty;
   } list_answer_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_operation = 1'b0;
   logic signed [VALUE_W-1:0]     req_value = '0;
   logic                          rsp_stall = 1'b0;
   wire                           req_stall;
   wire                           rsp_valid;
   wire [STATUS_W-1:0]            rsp_status;
   wire [COUNT_OUT_W-1:0]         rsp_entry_count;
   wire                           rsp_is_empty;

   list_request_type          request_q[$];
   list_answer_type           answer_q[$];
   logic signed [VALUE_W-1:0] held_values[$];

   logic signed [VALUE_W-1:0] model_store[CAPACITY];
   int                        model_count = 0;

   int   total_items = 1;
   int   beats_in = 0;
   int   mismatches = 0;
   int   quiet_cycles = 0;
   bit   req_taken = 1'b0;
   int   send_idle_pct;
   int   recv_idle_pct;
   list_answer_type  got, want;

   sorted_list_insert_remove DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #4 clock = ~clock;

   function automatic list_answer_type apply_list_request(list_request_type rq);
      list_answer_type ans;
      int pos;
      pos = 0;
      ans.status = STATUS_OK;
      if (rq.op == OP_INSERT) begin
         if (model_count >= CAPACITY) begin
            ans.status = STATUS_FULL;
         end else begin
            while (pos < model_count && model_store[pos] < rq.value) pos++;
            for (int i = model_count; i > pos; i--) model_store[i] = model_store[i-1];
            model_store[pos] = rq.value;
            model_count++;
         end
      end else begin
         if (model_count == 0) begin
            ans.status = STATUS_EMPTY;
         end else begin
            while (pos < model_count && model_store[pos] != rq.value) pos++;
            if (pos >= model_count) begin
               ans.status = STATUS_NOT_FOUND;
            end else begin
               for (int i = pos; i + 1 < model_count; i++) model_store[i] = model_store[i+1];
               model_count--;
            end
         end
      end
      ans.entry_count = model_count[COUNT_OUT_W-1:0];
      ans.is_empty    = (model_count == 0);
      return ans;
   endfunction

   // keeps a list of values the block should hold so removes can hit
   task automatic add_request(op_type op, logic signed [VALUE_W-1:0] value);
      list_request_type rq;
      int idx[$];
      rq.op    = op;
      rq.value = value;
      request_q.push_back(rq);
      if (op == OP_INSERT) begin
         if (held_values.size() < CAPACITY) held_values.push_back(value);
      end else begin
         idx = held_values.find_first_index(x) with (x == value);
         if (idx.size() > 0) held_values.delete(idx[0]);
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(9);
      if (r < 4) return $urandom_range(8) - 4;
      if (r == 4) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      int made;
      int burst;
      int mode;
      int len;
      bit ins;
      made  = 0;
      burst = 0;

      add_request(OP_REMOVE, 5);
      add_request(OP_INSERT, 0);
      add_request(OP_INSERT, 32'sh7fff_ffff);
      add_request(OP_INSERT, 32'sh8000_0000);
      add_request(OP_INSERT, -1);
      add_request(OP_INSERT, 1);
      add_request(OP_INSERT, 0);
      add_request(OP_INSERT, 32'sh7fff_ffff);
      add_request(OP_REMOVE, 7);
      add_request(OP_REMOVE, 0);
      add_request(OP_REMOVE, 32'sh7fff_ffff);
      add_request(OP_REMOVE, 32'sh8000_0000);
      add_request(OP_REMOVE, 32'sh8000_0000);
      add_request(OP_INSERT, 32'sh5555_5555);
      add_request(OP_INSERT, 32'shaaaa_aaaa);
      add_request(OP_REMOVE, 32'shaaaa_aaaa);
      add_request(OP_REMOVE, -1);
      add_request(OP_REMOVE, 0);
      add_request(OP_REMOVE, 1);
      add_request(OP_REMOVE, 32'sh7fff_ffff);
      add_request(OP_REMOVE, 32'sh5555_5555);
      add_request(OP_REMOVE, 0);

      // opening bursts fill past capacity, then drain past empty
      while (made < RANDOM_ITEMS) begin
         mode = (burst < 2) ? burst : $urandom_range(2);
         len  = (burst < 2) ? 72 : $urandom_range(60, 8);
         for (int k = 0; k < len; k++) begin
            if (burst >= 2 && $urandom_range(9) == 0) begin
               add_request(op_type'($urandom_range(1)), $urandom);
            end else begin
               case (mode)
                  0: ins = (burst < 2) || ($urandom_range(9) != 0);
                  1: ins = (burst >= 2) && ($urandom_range(9) == 0);
                  default: ins = $urandom_range(1);
               endcase
               if (ins)
                  add_request(OP_INSERT, pick_value());
               else if (held_values.size() > 0 && (burst < 2 || $urandom_range(9) != 0))
                  add_request(OP_REMOVE, held_values[$urandom_range(held_values.size() - 1)]);
               else
                  add_request(OP_REMOVE, pick_value());
            end
            made++;
         end
         burst++;
      end
      total_items = request_q.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() > 0 || answer_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         case (beats_in * 3 / total_items)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (!req_valid || req_taken) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_operation <= request_q[0].op;
               req_value     <= request_q[0].value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            void'(request_q.pop_front());
            answer_q.push_back(apply_list_request({op_type'(req_operation), req_value}));
            beats_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.status      = status_type'(rsp_status);
            got.entry_count = rsp_entry_count;
            got.is_empty    = rsp_is_empty;
            if (answer_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: status %0d count %0d empty %0d",
                           got.status, got.entry_count, got.is_empty);
            end else begin
               want = answer_q.pop_front();
               if (got.status !== want.status || got.entry_count !== want.entry_count ||
                   got.is_empty !== want.is_empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                              want.status, want.entry_count, want.is_empty,
                              got.status, got.entry_count, got.is_empty);
               end
            end
         end
         if (req_taken || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
